// ----- design/tcnt_pkg.sv -----
// Shared types and constants of the per-user traffic counter table.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package tcnt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int FIFO_DEPTH    = 2;
   localparam int FPTR_W        = $clog2(FIFO_DEPTH);

   localparam logic [31:0] UNKNOWN_USER   = 32'hFFFF_FFFF;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
   localparam logic [15:0] IPV4_MIN_BYTES = 16'd20;
   localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
   localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

   typedef enum logic [2:0] {
      ST_UNKNOWN  = 3'd0,
      ST_NOT_IPV4 = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_SCAN = 2'd1,
      BK_READ = 2'd2
   } back_state_type;

   // One classified packet as it travels from the front to the back.
   typedef struct packed {
      logic        early;
      status_type  status;
      logic        is_egress;
      logic [31:0] user_id;
      logic [31:0] packet_length;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } item_type;

endpackage

// ----- design/per_user_traffic_counter_table_top.sv -----
// Top level of the per-user traffic counter table.
// Depends on tcnt_pkg, tcnt_front, tcnt_fifo and tcnt_back.
`timescale 1ns / 1ps
// Each request beat summarizes one packet; each one yields exactly one response
// beat, in order. Beats with the unknown user id or that are not a full Ethernet
// plus IPv4 header are answered with only a status, without a table lookup in the
// back end. Every other beat is looked up in a 1024-entry table that is
// filled from the bottom and never emptied, so the valid entries are always a
// contiguous run counted by a fill register. The lookup walks that run through
// the single read port of the user-id memory, one entry per cycle, and stops
// early on a hit. A hit does a read-modify-write of the 64-bit counters; a miss
// writes a new entry at the fill position, or reports the table full. A two-deep
// queue decouples request acceptance from the lookup. The back end can go on
// scanning while a previous response waits in the response register, but it
// holds its own result until that response has been taken.
module per_user_traffic_counter_table_top import tcnt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_is_egress,
   input  logic [31:0] req_user_id,
   input  logic [31:0] req_packet_length,
   input  logic [15:0] req_captured_length,
   input  logic [15:0] req_ether_type,
   input  logic [3:0]  req_ip_header_words,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_tx_byte_count,
   output logic [63:0] rsp_rx_byte_count,
   output logic [63:0] rsp_tx_packet_count,
   output logic [63:0] rsp_rx_packet_count,
   output logic [31:0] rsp_first_source_address,
   output logic [31:0] rsp_first_dest_address,
   output logic [15:0] rsp_first_source_port,
   output logic [15:0] rsp_first_dest_port
);

   // Classified items between the front end and the queue.
   logic     q_push, q_full, q_pop, q_empty;
   item_type q_in_item, q_head_item;

   // The front end only classifies; it stalls when the queue is full.
   tcnt_front u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_is_egress       (req_is_egress),
      .req_user_id         (req_user_id),
      .req_packet_length   (req_packet_length),
      .req_captured_length (req_captured_length),
      .req_ether_type      (req_ether_type),
      .req_ip_header_words (req_ip_header_words),
      .req_ip_protocol     (req_ip_protocol),
      .req_source_address  (req_source_address),
      .req_dest_address    (req_dest_address),
      .req_source_port     (req_source_port),
      .req_dest_port       (req_dest_port),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (q_in_item)
   );

   tcnt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // The back end owns the table memories and the response register.
   tcnt_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .q_empty                  (q_empty),
      .q_item                   (q_head_item),
      .q_pop                    (q_pop),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_status               (rsp_status),
      .rsp_tx_byte_count        (rsp_tx_byte_count),
      .rsp_rx_byte_count        (rsp_rx_byte_count),
      .rsp_tx_packet_count      (rsp_tx_packet_count),
      .rsp_rx_packet_count      (rsp_rx_packet_count),
      .rsp_first_source_address (rsp_first_source_address),
      .rsp_first_dest_address   (rsp_first_dest_address),
      .rsp_first_source_port    (rsp_first_source_port),
      .rsp_first_dest_port      (rsp_first_dest_port)
   );

endmodule

// ----- design/tcnt_front.sv -----
// Front end: accepts packet beats and classifies them.
// Depends on tcnt_pkg.
`timescale 1ns / 1ps
module tcnt_front import tcnt_pkg::*; (
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_is_egress,
   input  logic [31:0] req_user_id,
   input  logic [31:0] req_packet_length,
   input  logic [15:0] req_captured_length,
   input  logic [15:0] req_ether_type,
   input  logic [3:0]  req_ip_header_words,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item
);

   logic [15:0] l4_start;
   logic        keep_ports;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      // Layer 4 offset is at most 74, so no sum below can overflow 16 bits.
      l4_start   = ETH_HDR_BYTES + {10'd0, req_ip_header_words, 2'b00};
      keep_ports = ((req_ip_protocol == PROTO_TCP) &&
                    (l4_start + TCP_HDR_BYTES <= req_captured_length)) ||
                   ((req_ip_protocol == PROTO_UDP) &&
                    (l4_start + UDP_HDR_BYTES <= req_captured_length));
      q_item.is_egress      = req_is_egress;
      q_item.user_id        = req_user_id;
      q_item.packet_length  = req_packet_length;
      q_item.source_address = req_source_address;
      q_item.dest_address   = req_dest_address;
      q_item.source_port    = keep_ports ? req_source_port : 16'd0;
      q_item.dest_port      = keep_ports ? req_dest_port : 16'd0;
      if (req_user_id == UNKNOWN_USER) begin
         q_item.early  = 1'b1;
         q_item.status = ST_UNKNOWN;
      end else if ((req_captured_length < ETH_HDR_BYTES) ||
                   (req_ether_type != ETHERTYPE_IPV4) ||
                   (req_captured_length < ETH_HDR_BYTES + IPV4_MIN_BYTES)) begin
         q_item.early  = 1'b1;
         q_item.status = ST_NOT_IPV4;
      end else begin
         q_item.early  = 1'b0;
         q_item.status = ST_UPDATED;
      end
   end

endmodule

// ----- design/tcnt_fifo.sv -----
// Short queue of classified items between the front and the back.
// Depends on tcnt_pkg.
`timescale 1ns / 1ps
module tcnt_fifo import tcnt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   item_type            slot_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FPTR_W:0]     fill_ff, fill_in;

   assign full      = (fill_ff == (FPTR_W+1)'(FIFO_DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (FPTR_W+1)'(push) - (FPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/tcnt_back.sv -----
// Back end: table lookup, insertion, counter update and result register.
// Depends on tcnt_pkg.
`timescale 1ns / 1ps
module tcnt_back import tcnt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_tx_byte_count,
   output logic [63:0] rsp_rx_byte_count,
   output logic [63:0] rsp_tx_packet_count,
   output logic [63:0] rsp_rx_packet_count,
   output logic [31:0] rsp_first_source_address,
   output logic [31:0] rsp_first_dest_address,
   output logic [15:0] rsp_first_source_port,
   output logic [15:0] rsp_first_dest_port
);

   logic [31:0] user_mem [TABLE_ENTRIES];
   logic [63:0] txb_mem  [TABLE_ENTRIES];
   logic [63:0] rxb_mem  [TABLE_ENTRIES];
   logic [63:0] txp_mem  [TABLE_ENTRIES];
   logic [63:0] rxp_mem  [TABLE_ENTRIES];
   logic [63:0] addr_mem [TABLE_ENTRIES];
   logic [31:0] port_mem [TABLE_ENTRIES];

   back_state_type    state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              pend_ff, pend_in;

   logic [31:0] user_rd_ff;
   logic [63:0] txb_rd_ff, rxb_rd_ff, txp_rd_ff, rxp_rd_ff, addr_rd_ff;
   logic [31:0] port_rd_ff;
   logic [IDX_W-1:0] cnt_raddr;

   logic              wr_cnt, wr_ins;
   logic [IDX_W-1:0]  wr_addr;
   logic [63:0]       txb_wr, rxb_wr, txp_wr, rxp_wr;

   logic        out_free, load, hit;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [63:0] txb_ff, txb_in, rxb_ff, rxb_in, txp_ff, txp_in, rxp_ff, rxp_in;
   logic [31:0] saddr_ff, saddr_in, daddr_ff, daddr_in;
   logic [15:0] sport_ff, sport_in, dport_ff, dport_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = pend_ff && (user_rd_ff == cur_ff.user_id);
   assign cnt_raddr = (state_ff == BK_SCAN) ? pidx_ff : hit_idx_ff;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      pidx_in    = pidx_ff;
      hit_idx_in = hit_idx_ff;
      pend_in    = pend_ff;
      q_pop      = 1'b0;
      wr_cnt     = 1'b0;
      wr_ins     = 1'b0;
      wr_addr    = hit_idx_ff;
      txb_wr     = '0;
      rxb_wr     = '0;
      txp_wr     = '0;
      rxp_wr     = '0;
      load       = 1'b0;
      status_in  = status_ff;
      txb_in     = '0;
      rxb_in     = '0;
      txp_in     = '0;
      rxp_in     = '0;
      saddr_in   = '0;
      daddr_in   = '0;
      sport_in   = '0;
      dport_in   = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_item.early) begin
                  if (out_free) begin
                     q_pop     = 1'b1;
                     load      = 1'b1;
                     status_in = q_item.status;
                  end
               end else begin
                  q_pop    = 1'b1;
                  cur_in   = q_item;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            if (hit) begin
               hit_idx_in = pidx_ff;
               pend_in    = 1'b0;
               state_in   = BK_READ;
            end else if (!pend_ff && (idx_ff == count_ff)) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = BK_IDLE;
                  if (count_ff == CNT_W'(TABLE_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_INSERTED;
                     wr_cnt    = 1'b1;
                     wr_ins    = 1'b1;
                     wr_addr   = count_ff[IDX_W-1:0];
                     txb_wr    = cur_ff.is_egress ? {32'd0, cur_ff.packet_length} : 64'd0;
                     rxb_wr    = cur_ff.is_egress ? 64'd0 : {32'd0, cur_ff.packet_length};
                     txp_wr    = {63'd0, cur_ff.is_egress};
                     rxp_wr    = {63'd0, !cur_ff.is_egress};
                     txb_in    = txb_wr;
                     rxb_in    = rxb_wr;
                     txp_in    = txp_wr;
                     rxp_in    = rxp_wr;
                     saddr_in  = cur_ff.source_address;
                     daddr_in  = cur_ff.dest_address;
                     sport_in  = cur_ff.source_port;
                     dport_in  = cur_ff.dest_port;
                     count_in  = count_ff + 1'b1;
                  end
               end
            end else if (idx_ff != count_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         BK_READ: begin
            txb_wr = txb_rd_ff;
            rxb_wr = rxb_rd_ff;
            txp_wr = txp_rd_ff;
            rxp_wr = rxp_rd_ff;
            if (cur_ff.is_egress) begin
               txb_wr = txb_rd_ff + {32'd0, cur_ff.packet_length};
               txp_wr = txp_rd_ff + 64'd1;
            end else begin
               rxb_wr = rxb_rd_ff + {32'd0, cur_ff.packet_length};
               rxp_wr = rxp_rd_ff + 64'd1;
            end
            if (out_free) begin
               wr_cnt    = 1'b1;
               load      = 1'b1;
               status_in = ST_UPDATED;
               txb_in    = txb_wr;
               rxb_in    = rxb_wr;
               txp_in    = txp_wr;
               rxp_in    = rxp_wr;
               saddr_in  = addr_rd_ff[63:32];
               daddr_in  = addr_rd_ff[31:0];
               sport_in  = port_rd_ff[31:16];
               dport_in  = port_rd_ff[15:0];
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      hit_idx_ff <= hit_idx_in;
      if (load) begin
         status_ff <= status_in;
         txb_ff    <= txb_in;
         rxb_ff    <= rxb_in;
         txp_ff    <= txp_in;
         rxp_ff    <= rxp_in;
         saddr_ff  <= saddr_in;
         daddr_ff  <= daddr_in;
         sport_ff  <= sport_in;
         dport_ff  <= dport_in;
      end
   end

   always_ff @(posedge clock) begin
      user_rd_ff <= user_mem[idx_ff[IDX_W-1:0]];
      txb_rd_ff  <= txb_mem[cnt_raddr];
      rxb_rd_ff  <= rxb_mem[cnt_raddr];
      txp_rd_ff  <= txp_mem[cnt_raddr];
      rxp_rd_ff  <= rxp_mem[cnt_raddr];
      addr_rd_ff <= addr_mem[cnt_raddr];
      port_rd_ff <= port_mem[cnt_raddr];
      if (wr_cnt) begin
         txb_mem[wr_addr] <= txb_wr;
         rxb_mem[wr_addr] <= rxb_wr;
         txp_mem[wr_addr] <= txp_wr;
         rxp_mem[wr_addr] <= rxp_wr;
      end
      if (wr_ins) begin
         user_mem[wr_addr] <= cur_ff.user_id;
         addr_mem[wr_addr] <= {cur_ff.source_address, cur_ff.dest_address};
         port_mem[wr_addr] <= {cur_ff.source_port, cur_ff.dest_port};
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_tx_byte_count        = txb_ff;
   assign rsp_rx_byte_count        = rxb_ff;
   assign rsp_tx_packet_count      = txp_ff;
   assign rsp_rx_packet_count      = rxp_ff;
   assign rsp_first_source_address = saddr_ff;
   assign rsp_first_dest_address   = daddr_ff;
   assign rsp_first_source_port    = sport_ff;
   assign rsp_first_dest_port      = dport_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("fill count beyond table size");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("queue popped while busy");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      wr_ins |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insertion did not advance fill count");
   a_scan_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan ran past filled entries");
`endif

endmodule

// ----- bench/per_user_traffic_counter_table_top_test.sv -----
// Self-checking testbench for the per-user traffic counter table top level.
// Depends on tcnt_pkg and per_user_traffic_counter_table_top.
`timescale 1ns / 1ps
module per_user_traffic_counter_table_top_test;
   import tcnt_pkg::*;

   // One packet summary as offered on the request channel.
   typedef struct {
      logic        is_egress;
      logic [31:0] user_id;
      logic [31:0] packet_length;
      logic [15:0] captured_length;
      logic [15:0] ether_type;
      logic [3:0]  ip_header_words;
      logic [7:0]  ip_protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } packet_type;

   // The response beat that a packet should produce.
   typedef struct {
      status_type  status;
      logic [63:0] tx_byte_total;
      logic [63:0] rx_byte_total;
      logic [63:0] tx_pkt_total;
      logic [63:0] rx_pkt_total;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } usage_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_is_egress = 1'b0;
   logic [31:0] req_user_id = '0;
   logic [31:0] req_packet_length = '0;
   logic [15:0] req_captured_length = '0;
   logic [15:0] req_ether_type = '0;
   logic [3:0]  req_ip_header_words = '0;
   logic [7:0]  req_ip_protocol = '0;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_dest_address = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_dest_port = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_tx_byte_count;
   logic [63:0] rsp_rx_byte_count;
   logic [63:0] rsp_tx_packet_count;
   logic [63:0] rsp_rx_packet_count;
   logic [31:0] rsp_first_source_address;
   logic [31:0] rsp_first_dest_address;
   logic [15:0] rsp_first_source_port;
   logic [15:0] rsp_first_dest_port;

   per_user_traffic_counter_table_top DUT (.*);

   // Shadow copy of the user table, kept up to date as request beats are accepted.
   logic        user_known  [TABLE_ENTRIES];
   logic [31:0] user_owner  [TABLE_ENTRIES];
   logic [63:0] user_tx_bytes   [TABLE_ENTRIES];
   logic [63:0] user_rx_bytes   [TABLE_ENTRIES];
   logic [63:0] user_tx_packets [TABLE_ENTRIES];
   logic [63:0] user_rx_packets [TABLE_ENTRIES];
   logic [31:0] user_saddr  [TABLE_ENTRIES];
   logic [31:0] user_daddr  [TABLE_ENTRIES];
   logic [15:0] user_sport  [TABLE_ENTRIES];
   logic [15:0] user_dport  [TABLE_ENTRIES];
   int          users_in_table = 0;

   usage_type   pending_usage[$];
   bit          failed = 1'b0;
   bit          no_idle = 1'b0;       // when set, neither side inserts gaps
   logic        hold_responses = 1'b0; // long receiver hold-off for back pressure
   int          stall_left = 0;
   logic [31:0] user_pool[48];

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Computes the response for one packet and updates the shadow table. Packets
   // from the unknown user or without a complete Ethernet plus IPv4 header leave
   // the table untouched and come back with only a status.
   function automatic usage_type account_packet(packet_type p);
      usage_type u;
      int slot;
      int l4_start;
      u = '{status: ST_UNKNOWN, default: '0};
      if (p.user_id == UNKNOWN_USER) return u;
      u.status = ST_NOT_IPV4;
      if (p.captured_length < ETH_HDR_BYTES || p.ether_type != ETHERTYPE_IPV4 ||
          p.captured_length < ETH_HDR_BYTES + IPV4_MIN_BYTES) return u;
      slot = -1;
      for (int k = 0; k < TABLE_ENTRIES; k++)
         if (slot < 0 && user_known[k] && user_owner[k] == p.user_id) slot = k;
      if (slot >= 0) begin
         u.status = ST_UPDATED;
         if (p.is_egress) begin
            user_tx_bytes[slot] += 64'(p.packet_length);
            user_tx_packets[slot] += 64'd1;
         end else begin
            user_rx_bytes[slot] += 64'(p.packet_length);
            user_rx_packets[slot] += 64'd1;
         end
      end else begin
         for (int k = TABLE_ENTRIES - 1; k >= 0; k--)
            if (!user_known[k]) slot = k;
         if (slot < 0) begin
            u.status = ST_FULL;
            return u;
         end
         u.status = ST_INSERTED;
         users_in_table++;
         user_known[slot]      = 1'b1;
         user_owner[slot]      = p.user_id;
         user_tx_bytes[slot]   = p.is_egress ? 64'(p.packet_length) : 64'd0;
         user_rx_bytes[slot]   = p.is_egress ? 64'd0 : 64'(p.packet_length);
         user_tx_packets[slot] = p.is_egress ? 64'd1 : 64'd0;
         user_rx_packets[slot] = p.is_egress ? 64'd0 : 64'd1;
         user_saddr[slot]      = p.source_address;
         user_daddr[slot]      = p.dest_address;
         // Ports are kept only when the whole transport header was captured.
         l4_start = 14 + 4 * p.ip_header_words;
         if ((p.ip_protocol == PROTO_TCP && l4_start + 20 <= p.captured_length) ||
             (p.ip_protocol == PROTO_UDP && l4_start + 8 <= p.captured_length)) begin
            user_sport[slot] = p.source_port;
            user_dport[slot] = p.dest_port;
         end else begin
            user_sport[slot] = '0;
            user_dport[slot] = '0;
         end
      end
      u.tx_byte_total  = user_tx_bytes[slot];
      u.rx_byte_total  = user_rx_bytes[slot];
      u.tx_pkt_total   = user_tx_packets[slot];
      u.rx_pkt_total   = user_rx_packets[slot];
      u.source_address = user_saddr[slot];
      u.dest_address   = user_daddr[slot];
      u.source_port    = user_sport[slot];
      u.dest_port      = user_dport[slot];
      return u;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 18);
   endfunction

   // An IPv4 packet with random content for the given user.
   function automatic packet_type ipv4_packet(logic [31:0] user);
      packet_type p;
      p.is_egress       = 1'($urandom_range(0, 1));
      p.user_id         = user;
      p.packet_length   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1600);
      p.captured_length = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(34, 100));
      p.ether_type      = ETHERTYPE_IPV4;
      p.ip_header_words = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
      case ($urandom_range(0, 3))
         0: p.ip_protocol = 8'($urandom);
         1, 2: p.ip_protocol = PROTO_TCP;
         default: p.ip_protocol = PROTO_UDP;
      endcase
      p.source_address  = $urandom;
      p.dest_address    = $urandom;
      p.source_port     = 16'($urandom);
      p.dest_port       = 16'($urandom);
      return p;
   endfunction

   // Offers one request beat, records its expected response once it is taken,
   // then idles for a random gap. Valid stays high when the gap is zero.
   task automatic send_packet(packet_type p);
      int gap;
      req_valid           <= 1'b1;
      req_is_egress       <= p.is_egress;
      req_user_id         <= p.user_id;
      req_packet_length   <= p.packet_length;
      req_captured_length <= p.captured_length;
      req_ether_type      <= p.ether_type;
      req_ip_header_words <= p.ip_header_words;
      req_ip_protocol     <= p.ip_protocol;
      req_source_address  <= p.source_address;
      req_dest_address    <= p.dest_address;
      req_source_port     <= p.source_port;
      req_dest_port       <= p.dest_port;
      do @(posedge clock); while (req_stall);
      pending_usage.push_back(account_packet(p));
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: checks every accepted response beat against the oldest expected
   // one and draws a fresh stall length after each beat it takes.
   always @(posedge clock) begin
      usage_type u;
      logic stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_usage.size() == 0) begin
            $display("%0t: response beat with none expected, status %0d",
                     $time, rsp_status);
            failed = 1'b1;
         end else begin
            u = pending_usage.pop_front();
            if (rsp_status !== u.status) begin
               $display("%0t: status expected %0d actual %0d", $time, u.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_tx_byte_count !== u.tx_byte_total) begin
               $display("%0t: tx bytes expected %0h actual %0h", $time, u.tx_byte_total,
                        rsp_tx_byte_count);
               failed = 1'b1;
            end
            if (rsp_rx_byte_count !== u.rx_byte_total) begin
               $display("%0t: rx bytes expected %0h actual %0h", $time, u.rx_byte_total,
                        rsp_rx_byte_count);
               failed = 1'b1;
            end
            if (rsp_tx_packet_count !== u.tx_pkt_total) begin
               $display("%0t: tx packets expected %0h actual %0h", $time, u.tx_pkt_total,
                        rsp_tx_packet_count);
               failed = 1'b1;
            end
            if (rsp_rx_packet_count !== u.rx_pkt_total) begin
               $display("%0t: rx packets expected %0h actual %0h", $time, u.rx_pkt_total,
                        rsp_rx_packet_count);
               failed = 1'b1;
            end
            if (rsp_first_source_address !== u.source_address) begin
               $display("%0t: source address expected %0h actual %0h", $time,
                        u.source_address, rsp_first_source_address);
               failed = 1'b1;
            end
            if (rsp_first_dest_address !== u.dest_address) begin
               $display("%0t: dest address expected %0h actual %0h", $time,
                        u.dest_address, rsp_first_dest_address);
               failed = 1'b1;
            end
            if (rsp_first_source_port !== u.source_port) begin
               $display("%0t: source port expected %0h actual %0h", $time,
                        u.source_port, rsp_first_source_port);
               failed = 1'b1;
            end
            if (rsp_first_dest_port !== u.dest_port) begin
               $display("%0t: dest port expected %0h actual %0h", $time,
                        u.dest_port, rsp_first_dest_port);
               failed = 1'b1;
            end
         end
         stall_left = draw_gap();
      end
      if (hold_responses) begin
         stall_next = 1'b1;
      end else if (stall_left > 0) begin
         stall_next = 1'b1;
         stall_left--;
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // Header decoding corners: unknown user, short frames, wrong ethertype,
   // transport headers that do or do not fit, odd header lengths.
   task automatic test_header_corners();
      packet_type p;
      p = ipv4_packet(32'h0000_0000);
      p.user_id = UNKNOWN_USER;                 send_packet(p);
      p = ipv4_packet(32'h0000_0000); p.captured_length = 16'd13; send_packet(p);
      p = ipv4_packet(32'h0000_0000); p.captured_length = 16'd33; send_packet(p);
      p = ipv4_packet(32'h0000_0000); p.ether_type = 16'h86DD;   send_packet(p);
      p = ipv4_packet(32'h0000_0000); p.ether_type = 16'hFFFF;   send_packet(p);
      // Smallest frame that counts; TCP header does not fit.
      p = ipv4_packet(32'h0000_0000);
      p.captured_length = 16'd34; p.ip_protocol = PROTO_TCP; p.ip_header_words = 4'd5;
      p.is_egress = 1'b1; p.packet_length = 32'hFFFF_FFFF;
      send_packet(p);
      // TCP header exactly fits, and one byte short.
      p = ipv4_packet(32'h0000_0001);
      p.captured_length = 16'd54; p.ip_protocol = PROTO_TCP; p.ip_header_words = 4'd5;
      send_packet(p);
      p = ipv4_packet(32'h0000_0002);
      p.captured_length = 16'd53; p.ip_protocol = PROTO_TCP; p.ip_header_words = 4'd5;
      send_packet(p);
      // UDP exactly fits, and one byte short.
      p = ipv4_packet(32'h0000_0003);
      p.captured_length = 16'd42; p.ip_protocol = PROTO_UDP; p.ip_header_words = 4'd5;
      send_packet(p);
      p = ipv4_packet(32'h0000_0004);
      p.captured_length = 16'd41; p.ip_protocol = PROTO_UDP; p.ip_header_words = 4'd5;
      send_packet(p);
      // Header length of zero words and of fifteen words.
      p = ipv4_packet(32'h0000_0005);
      p.captured_length = 16'd34; p.ip_protocol = PROTO_TCP; p.ip_header_words = 4'd0;
      send_packet(p);
      p = ipv4_packet(32'h0000_0006);
      p.captured_length = 16'hFFFF; p.ip_protocol = PROTO_UDP; p.ip_header_words = 4'hF;
      p.source_port = 16'hFFFF; p.dest_port = 16'hFFFF;
      send_packet(p);
      // Some other protocol never keeps ports.
      p = ipv4_packet(32'h0000_0007);
      p.captured_length = 16'd1500; p.ip_protocol = 8'hFF;
      send_packet(p);
   endtask

   // Hits on existing users in both directions, including large lengths.
   task automatic test_counter_updates();
      packet_type p;
      for (int i = 0; i < 8; i++) begin
         p = ipv4_packet(32'(i % 3));
         p.is_egress = i[0];
         p.packet_length = (i < 4) ? 32'hFFFF_FFFF : 32'(i);
         p.source_address = 32'hFFFF_FFFF;
         send_packet(p);
      end
   endtask

   // Mostly well-formed packets from a small pool of users with random content,
   // the rest unknown users and random noise. Idling turns off now and then.
   task automatic test_random_traffic();
      packet_type p;
      for (int i = 0; i < 1000; i++) begin
         if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 9))
            0: begin
               p = ipv4_packet(user_pool[$urandom_range(0, 47)]);
               p.user_id = UNKNOWN_USER;
            end
            1: begin
               p = ipv4_packet($urandom);
               p.captured_length = 16'($urandom);
               p.ether_type      = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                               : ETHERTYPE_IPV4;
               p.captured_length = ($urandom_range(0, 1) == 0)
                                   ? 16'($urandom_range(0, 40)) : p.captured_length;
            end
            default: p = ipv4_packet(user_pool[$urandom_range(0, 47)]);
         endcase
         send_packet(p);
      end
      no_idle = 1'b0;
   endtask

   // The receiver holds off for a long stretch while packets keep coming, so the
   // internal queue and response register fill up and the request side stalls.
   task automatic test_back_pressure();
      fork
         begin
            hold_responses <= 1'b1;
            repeat (400) @(posedge clock);
            hold_responses <= 1'b0;
         end
      join_none
      no_idle = 1'b1;
      for (int i = 0; i < 12; i++) send_packet(ipv4_packet(user_pool[$urandom_range(0, 47)]));
      no_idle = 1'b0;
   endtask

   // Fills every free entry, then checks misses on a full table, a hit on the
   // last entry and the early-out statuses while the table is full.
   task automatic test_table_full();
      packet_type p;
      int n;
      no_idle = 1'b1;
      n = 0;
      while (users_in_table < TABLE_ENTRIES) begin
         send_packet(ipv4_packet(32'h4000_0000 + 32'(n)));
         n++;
      end
      no_idle = 1'b0;
      for (int i = 0; i < 6; i++) begin
         send_packet(ipv4_packet(32'h8000_0000 + 32'(i)));
         send_packet(ipv4_packet(32'h4000_0000 + 32'(n - 1)));
      end
      p = ipv4_packet(32'h0000_0000); p.user_id = UNKNOWN_USER; send_packet(p);
      p = ipv4_packet(32'hDEAD_0000); p.captured_length = 16'd0; send_packet(p);
   endtask

   initial begin
      for (int k = 0; k < TABLE_ENTRIES; k++) user_known[k] = 1'b0;
      foreach (user_pool[i]) begin
         user_pool[i] = $urandom;
         if (user_pool[i] == UNKNOWN_USER) user_pool[i] = 32'h7FFF_FFFF;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_corners();
      test_counter_updates();
      test_random_traffic();
      test_back_pressure();
      test_table_full();
      req_valid <= 1'b0;
      while (pending_usage.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- per_user_traffic_counter_table_top.f -----
design/tcnt_pkg.sv
design/tcnt_front.sv
design/tcnt_fifo.sv
design/tcnt_back.sv
design/per_user_traffic_counter_table_top.sv
bench/per_user_traffic_counter_table_top_test.sv
